@@ sv/trq_pkg.sv @@
// ----------------------------------------------------------------------------
// trq_pkg: thread ready-queue scheduler package
// shared widths, request and status codes, cell command and free id search
// ----------------------------------------------------------------------------
package trq_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W        = 4;
    localparam int CNT_W       = 5;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef logic [ID_W-1:0]        t_id;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [MAX_THREADS-1:0] t_live;

    typedef enum logic [KIND_W-1:0] {
        K_SPAWN = 2'd0,
        K_YIELD = 2'd1,
        K_EXIT  = 2'd2,
        K_SCHED = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_TARGET = 2'd1,
        ST_NO_FREE    = 2'd2,
        ST_HALTED     = 2'd3
    } t_status;

    typedef struct packed {
        logic upd;
        logic rm_en;
        t_id  rm_id;
        logic ap_en;
        t_id  ap_id;
    } t_cell_cmd;

    typedef struct packed {
        logic found;
        t_id  id;
    } t_pick;

    // first id not live after the last spawned one, cyclically
    function automatic t_pick next_free(t_live live, t_id last);
        t_pick p;
        t_id   idx;
        p.found = 1'b0;
        p.id    = '0;
        for (int j = 0; j < MAX_THREADS; j++) begin
            idx = last + ID_W'(j + 1);
            if (!p.found && !live[idx]) begin
                p.found = 1'b1;
                p.id    = idx;
            end
        end
        return p;
    endfunction

endpackage

@@ sv/trq_cell.sv @@
// ----------------------------------------------------------------------------
// trq_cell: one slot of the ready list
// holds one id and its valid bit, closes gaps on removal and takes an append
// ----------------------------------------------------------------------------
module trq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_init_vld,
    input  trq_pkg::t_cell_cmd i_cmd,
    input  logic               i_seen,
    input  logic               i_prev_pv,
    input  trq_pkg::t_id       i_nxt_id,
    input  logic               i_nxt_vld,
    output logic               o_seen,
    output logic               o_pv,
    output trq_pkg::t_id       o_id,
    output logic               o_vld,
    output trq_pkg::t_id       o_n_id
);
    import trq_pkg::*;

    t_id  r_id;
    logic r_vld;
    t_id  n_id;
    logic n_vld;
    t_id  w_rem_id;
    logic w_rem_vld;
    logic w_take;

    always_comb begin
        o_seen    = i_seen | (r_vld & i_cmd.rm_en & (r_id == i_cmd.rm_id));
        w_rem_id  = o_seen ? i_nxt_id  : r_id;
        w_rem_vld = o_seen ? i_nxt_vld : r_vld;
        w_take    = i_cmd.ap_en & ~w_rem_vld & i_prev_pv;
        n_id      = w_take ? i_cmd.ap_id : w_rem_id;
        n_vld     = w_take | w_rem_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id  <= '0;
            r_vld <= i_init_vld;
        end else if (i_cmd.upd) begin
            r_id  <= n_id;
            r_vld <= n_vld;
        end
    end

    assign o_pv   = w_rem_vld;
    assign o_id   = r_id;
    assign o_vld  = r_vld;
    assign o_n_id = n_id;

endmodule

@@ sv/trq_chain.sv @@
// ----------------------------------------------------------------------------
// trq_chain: row of ready list cells
// head at cell 0, each cell takes its right neighbour's slot on removal
// ----------------------------------------------------------------------------
module trq_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trq_pkg::t_cell_cmd i_cmd,
    output trq_pkg::t_id       o_head_next
);
    import trq_pkg::*;

    logic w_seen [0:MAX_THREADS];
    logic w_pv   [0:MAX_THREADS];
    t_id  w_id   [0:MAX_THREADS];
    logic w_vld  [0:MAX_THREADS];
    t_id  w_n_id [0:MAX_THREADS-1];

    assign w_seen[0]          = 1'b0;
    assign w_pv[0]            = 1'b1;
    assign w_id[MAX_THREADS]  = '0;
    assign w_vld[MAX_THREADS] = 1'b0;

    for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
        trq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init_vld (g == 0),
            .i_cmd      (i_cmd),
            .i_seen     (w_seen[g]),
            .i_prev_pv  (w_pv[g]),
            .i_nxt_id   (w_id[g+1]),
            .i_nxt_vld  (w_vld[g+1]),
            .o_seen     (w_seen[g+1]),
            .o_pv       (w_pv[g+1]),
            .o_id       (w_id[g]),
            .o_vld      (w_vld[g]),
            .o_n_id     (w_n_id[g])
        );
    end

    assign o_head_next = w_n_id[0];

endmodule

@@ sv/thread_ready_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// thread_ready_queue_scheduler: round-robin fifo scheduler for 16 thread ids
// spawn, yield, exit and schedule requests over a cell-chain ready list
// ----------------------------------------------------------------------------
// Each request is taken in while in S_IDLE; in S_EXEC the ready list cells
// match, close the gap and append in a single pass and the result is loaded
// into the output register. A new request is taken as soon as that
// result is registered, even while it still waits on m_axis_tready; the
// update cycle stalls only while an earlier result is still held. The
// request kind travels on s_axis_tuser, the yield target on s_axis_tdata.
// Once the list empties the block answers every request as halted until
// reset.
module thread_ready_queue_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] target
    input  logic [trq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] kind
    input  logic [trq_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] status, [5:2] thread_id, [9:6] running_now, [14:10] ready_count
    output logic [trq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import trq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state    r_state, n_state;
    t_kind     r_kind;
    t_id       r_target;
    t_live     r_live, n_live;
    t_id       r_run, n_run;
    t_id       r_last, n_last;
    t_cnt      r_len, n_len;
    logic      r_halt, n_halt;
    logic      r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    t_cell_cmd w_cmd;
    t_id       w_head_next;
    t_pick     w_pick;
    logic      w_go;
    t_status   w_status;
    t_id       w_tid;
    t_id       w_run_out;

    trq_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_head_next (w_head_next)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_go   = (r_state == S_EXEC) && (!r_out_vld || m_axis_tready);
    assign w_pick = next_free(r_live, r_last);

    always_comb begin
        w_cmd    = '0;
        n_live   = r_live;
        n_run    = r_run;
        n_last   = r_last;
        n_len    = r_len;
        n_halt   = r_halt;
        w_status = ST_OK;
        w_tid    = '0;
        if (r_halt) begin
            w_status = ST_HALTED;
        end else begin
            case (r_kind)
                K_SPAWN: begin
                    if (!w_pick.found) begin
                        w_status = ST_NO_FREE;
                    end else begin
                        n_live[w_pick.id] = 1'b1;
                        n_last      = w_pick.id;
                        n_len       = r_len + 1'b1;
                        w_cmd.ap_en = 1'b1;
                        w_cmd.ap_id = w_pick.id;
                        w_tid       = w_pick.id;
                    end
                end
                K_YIELD: begin
                    if (!r_live[r_target]) begin
                        w_status = ST_BAD_TARGET;
                    end else begin
                        w_tid = r_run;
                        if (r_target != r_run) begin
                            w_cmd.rm_en = 1'b1;
                            w_cmd.rm_id = r_run;
                            w_cmd.ap_en = 1'b1;
                            w_cmd.ap_id = r_run;
                            n_run       = r_target;
                        end
                    end
                end
                K_EXIT: begin
                    w_tid          = r_run;
                    n_live[r_run]  = 1'b0;
                    w_cmd.rm_en    = 1'b1;
                    w_cmd.rm_id    = r_run;
                    n_len          = r_len - 1'b1;
                    if (n_len == '0) begin
                        n_halt   = 1'b1;
                        n_run    = '0;
                        w_status = ST_HALTED;
                    end else begin
                        n_run = w_head_next;
                    end
                end
                K_SCHED: begin
                    w_tid       = r_run;
                    w_cmd.rm_en = 1'b1;
                    w_cmd.rm_id = r_run;
                    w_cmd.ap_en = 1'b1;
                    w_cmd.ap_id = r_run;
                    n_run       = w_head_next;
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end
        w_cmd.upd  = w_go;
        w_run_out  = n_halt ? '0 : n_run;
        n_out_data = {1'b0, (n_halt ? t_cnt'(0) : n_len), w_run_out, w_tid, w_status};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= t_live'(1);
            r_run     <= '0;
            r_last    <= '0;
            r_len     <= t_cnt'(1);
            r_halt    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_live    <= n_live;
                r_run     <= n_run;
                r_last    <= n_last;
                r_len     <= n_len;
                r_halt    <= n_halt;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind   <= t_kind'(s_axis_tuser);
            r_target <= s_axis_tdata[ID_W-1:0];
        end
        if (w_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule
